// ===== rtl/core/pllrwg_pkg.sv =====
// Shared types and constants for the PLL register word generator.
// No dependencies.
`default_nettype none
package pllrwg_pkg;
  localparam int unsigned REF_W    = 24;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned TGT_W    = 23;
  localparam int unsigned SCALED_W = 30;
  localparam logic [22:0] DIV_NUMERATOR = 23'd4400000;
  localparam logic [31:0] WORD_R5      = 32'h00580005;
  localparam logic [31:0] WORD_R4_BASE = 32'h00850404;
  localparam logic [31:0] WORD_R3      = 32'h000004B3;
  localparam logic [31:0] WORD_R2      = 32'h18004FC2;
  localparam logic [31:0] WORD_R1_BASE = 32'h08008001;
  localparam logic [31:0] WORD_R0_BASE = 32'h00000000;
  localparam logic [31:0] POWER_BITS   = 32'h00000008;
  localparam logic [0:0] CFG_REFERENCE = 1'b0;
  localparam logic [0:0] CFG_STEP      = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic [SCALED_W-1:0] scaled;
    logic [STEP_W-1:0]   step;
    logic [REF_W-1:0]    refk;
    logic [2:0]          dexp;
    logic                enable;
  } job_t;

  // serial unsigned divide: n bits of quotient, one per cycle
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_R1   = 4'b0010,
    ST_INT  = 4'b0100,
    ST_FRAC = 4'b1000
  } bst_t;
endpackage
`default_nettype wire

// ===== rtl/core/pllrwg_front.sv =====
// Front end: accepts a target, finds the output divider exponent with a
// serial divide of 4400000 by the target, then pushes a job. Uses pllrwg_pkg.
`default_nettype none
module pllrwg_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [pllrwg_pkg::TGT_W-1:0]   target,
  input  wire logic                           enable,
  input  wire logic [pllrwg_pkg::REF_W-1:0]   refk,
  input  wire logic [pllrwg_pkg::STEP_W-1:0]  step,
  output      logic                           job_valid,
  input  wire logic                           job_ready,
  output      pllrwg_pkg::job_t               job
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [22:0] tgt_r, tgt_nxt;
  logic        en_r, en_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [22:0] quo_r, quo_nxt;
  logic [23:0] trial;
  logic [2:0]  dexp;

  assign in_ready  = !busy_r && !done_r;
  assign job_valid = done_r;
  assign trial = {rem_r, pllrwg_pkg::DIV_NUMERATOR[cnt_r]};

  always_comb begin
    if (tgt_r == '0 || quo_r >= 23'd128) dexp = 3'd7;
    else if (quo_r[6]) dexp = 3'd6;
    else if (quo_r[5]) dexp = 3'd5;
    else if (quo_r[4]) dexp = 3'd4;
    else if (quo_r[3]) dexp = 3'd3;
    else if (quo_r[2]) dexp = 3'd2;
    else if (quo_r[1]) dexp = 3'd1;
    else dexp = 3'd0;
  end

  always_comb begin
    busy_nxt = busy_r; done_nxt = done_r; cnt_nxt = cnt_r;
    tgt_nxt = tgt_r; en_nxt = en_r; rem_nxt = rem_r; quo_nxt = quo_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1; cnt_nxt = 5'd22; tgt_nxt = target; en_nxt = enable;
      rem_nxt = '0; quo_nxt = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, tgt_r}) begin
        rem_nxt = 23'(trial - {1'b0, tgt_r});
        quo_nxt = {quo_r[21:0], 1'b1};
      end else begin
        rem_nxt = trial[22:0];
        quo_nxt = {quo_r[21:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end else if (done_r && job_ready) begin
      done_nxt = 1'b0;
    end
  end

  always_comb begin
    job.scaled = pllrwg_pkg::SCALED_W'({7'd0, tgt_r} << dexp);
    job.step   = pllrwg_pkg::STEP_W'({3'd0, step} << dexp);
    job.refk   = refk;
    job.dexp   = dexp;
    job.enable = en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; tgt_r <= tgt_nxt; en_r <= en_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/pllrwg_queue.sv =====
// Two-entry job queue between front and back. Uses pllrwg_pkg.
`default_nettype none
module pllrwg_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output      logic             wr_ready,
  input  wire pllrwg_pkg::job_t wr_job,
  output      logic             rd_valid,
  input  wire logic             rd_ready,
  output      pllrwg_pkg::job_t rd_job
);
  pllrwg_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
    if (push) mem_r[wp_r] <= wr_job;
  end
endmodule
`default_nettype wire

// ===== rtl/core/pllrwg_back.sv =====
// Back end: three serial divides (ref/step, scaled/ref, rem/step), then
// streams six register words. Uses pllrwg_pkg.
`default_nettype none
module pllrwg_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  output      logic             job_ready,
  input  wire pllrwg_pkg::job_t job,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [31:0]      word,
  output      logic [2:0]       num,
  output      logic             last,
  output      logic             err
);
  pllrwg_pkg::bst_t st_r, st_nxt;
  pllrwg_pkg::job_t j_r;
  logic [29:0] dvd_r;
  logic [23:0] dvs;
  logic [23:0] rem_r;
  logic [29:0] quo_r;
  logic [4:0]  cnt_r;
  logic [24:0] trial;
  logic        tge;
  logic [23:0] tnext;
  logic [29:0] r1q_r, int_r;
  logic        sending_r;
  logic [2:0]  num_r;
  logic        step_z, ref_z;
  logic [31:0] w4, w1, w0;

  assign step_z = j_r.step == '0;
  assign ref_z  = j_r.refk == '0;
  assign dvs    = (st_r == pllrwg_pkg::ST_INT) ? j_r.refk : {8'd0, j_r.step};
  assign trial  = {rem_r, dvd_r[cnt_r]};
  // restoring step: for a nonzero divisor the partial remainder stays below it
  assign tge    = trial >= {1'b0, dvs};
  assign tnext  = tge ? 24'(trial - {1'b0, dvs}) : trial[23:0];
  assign job_ready = st_r == pllrwg_pkg::ST_IDLE && !sending_r;
  assign out_valid = sending_r;

  assign w4 = pllrwg_pkg::WORD_R4_BASE | ({29'd0, j_r.dexp} << 20)
            | ({31'd0, j_r.enable} << 5) | pllrwg_pkg::POWER_BITS;
  assign w1 = ({r1q_r[28:0], 3'd0}) | pllrwg_pkg::WORD_R1_BASE;
  assign w0 = ({quo_r[28:0], 3'd0}) | ({int_r[16:0], 15'd0})
            | pllrwg_pkg::WORD_R0_BASE;

  always_comb begin
    case (num_r)
      3'd5: word = pllrwg_pkg::WORD_R5;
      3'd4: word = w4;
      3'd3: word = pllrwg_pkg::WORD_R3;
      3'd2: word = pllrwg_pkg::WORD_R2;
      3'd1: word = w1;
      default: word = step_z ? (({int_r[16:0], 15'd0}) | pllrwg_pkg::WORD_R0_BASE) : w0;
    endcase
  end
  assign num  = num_r;
  assign last = num_r == 3'd0;
  assign err  = step_z;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pllrwg_pkg::ST_IDLE: if (job_valid && job_ready) st_nxt = pllrwg_pkg::ST_R1;
      pllrwg_pkg::ST_R1:   if (cnt_r == '0) st_nxt = pllrwg_pkg::ST_INT;
      pllrwg_pkg::ST_INT:  if (cnt_r == '0) st_nxt = pllrwg_pkg::ST_FRAC;
      pllrwg_pkg::ST_FRAC: if (cnt_r == '0) st_nxt = pllrwg_pkg::ST_IDLE;
      default: st_nxt = pllrwg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pllrwg_pkg::ST_IDLE; sending_r <= 1'b0; num_r <= 3'd5;
    end else begin
      st_r <= st_nxt;
      if (st_r == pllrwg_pkg::ST_FRAC && cnt_r == '0) begin
        sending_r <= 1'b1; num_r <= 3'd5;
      end else if (sending_r && out_ready) begin
        if (num_r == 3'd0) sending_r <= 1'b0;
        else num_r <= num_r - 3'd1;
      end
    end
    case (st_r)
      pllrwg_pkg::ST_IDLE: begin
        // job and results stay put while the words go out
        if (job_valid && job_ready) begin
          j_r <= job; dvd_r <= {6'd0, job.refk}; rem_r <= '0;
          quo_r <= '0; cnt_r <= 5'd23;
        end
      end
      default: begin
        if (cnt_r == '0) begin
          rem_r <= '0;
          if (st_r == pllrwg_pkg::ST_R1) begin
            quo_r <= '0;
            r1q_r <= step_z ? '0 : {quo_r[28:0], tge};
            dvd_r <= j_r.scaled; cnt_r <= 5'd29;
          end else if (st_r == pllrwg_pkg::ST_INT) begin
            quo_r <= '0;
            int_r <= ref_z ? '0 : {quo_r[28:0], tge};
            dvd_r <= {6'd0, ref_z ? 24'd0 : tnext};
            cnt_r <= 5'd23;
          end else begin
            quo_r <= {quo_r[28:0], tge};
          end
        end else begin
          rem_r <= tnext;
          quo_r <= {quo_r[28:0], tge};
          cnt_r <= cnt_r - 5'd1;
        end
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/pll_register_word_generator_top.sv =====
// PLL register word generator: a target frequency in, six register words out
// (R5..R0). Front: serial divide for the output divider exponent. Back: three
// serial divides, then one word a cycle while out_tready is high. Front and
// back overlap through a 2-entry queue.
// rst_n is synchronous, active low; registers reset to 10000 kHz and 100 kHz.
`default_nettype none
module pll_register_word_generator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,   // [22:0] target_khz, [23] output_enable
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [31:0] reg_word, [34:32] reg_number,
                                       // [35] div_error, rest zero
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [23:0] ref_r;
  logic [15:0] step_r;
  logic        fv, fr, bv, br;
  pllrwg_pkg::job_t fj, bj;
  logic [31:0] word;
  logic [2:0]  num;
  logic        err;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= 24'd10000; step_r <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        pllrwg_pkg::CFG_REFERENCE: ref_r <= cfg_data;
        pllrwg_pkg::CFG_STEP:      step_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pllrwg_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .target(in_tdata[22:0]), .enable(in_tdata[23]), .refk(ref_r), .step(step_r),
    .job_valid(fv), .job_ready(fr), .job(fj));

  pllrwg_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(bv), .rd_ready(br), .rd_job(bj));

  pllrwg_back u_back (
    .clk, .rst_n, .job_valid(bv), .job_ready(br), .job(bj),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .word, .num, .last(out_tlast), .err);

  assign out_tdata = {4'd0, err, num, word};
endmodule
`default_nettype wire
